[rtl/core/pctt_pkg.sv]
// Package with types and constants shared by the pending command timeout tracker.
`timescale 1ns / 1ps
package pctt_pkg;

   localparam int DefaultTableDepth = 16;
   localparam logic [15:0] DefaultDeadlineMs = 16'd1000;

   // Request operation codes.
   localparam logic [2:0] OP_REGISTER = 3'd0;
   localparam logic [2:0] OP_RESOLVE  = 3'd1;
   localparam logic [2:0] OP_EPOCH    = 3'd2;
   localparam logic [2:0] OP_DROP     = 3'd3;
   localparam logic [2:0] OP_TICK     = 3'd4;

   // Result kinds.
   localparam logic [2:0] KIND_REGISTERED = 3'd0;
   localparam logic [2:0] KIND_FULL       = 3'd1;
   localparam logic [2:0] KIND_RESOLVED   = 3'd2;
   localparam logic [2:0] KIND_MISS       = 3'd3;
   localparam logic [2:0] KIND_SUPERSEDED = 3'd4;
   localparam logic [2:0] KIND_TIMEOUT    = 3'd5;
   localparam logic [2:0] KIND_END        = 3'd6;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_PICK,
      ST_EMIT,
      ST_END
   } state_type;

endpackage

[rtl/core/pending_command_timeout_tracker.sv]
// Top level of the pending command timeout tracker: slot table and scan sequencer.
`timescale 1ns / 1ps
// Usage: a request is taken when start is high and busy is low. Each result
// appears for one cycle with rsp_valid high; rsp_last marks the final result
// of a request. The receiver cannot stall, so results go out as produced.
// The csr port writes deadline_ms; a write of zero stores 1000. Write it
// only while busy is low.
// Timing: every request first scans all TABLE_DEPTH slots, one slot per
// cycle through a single shared compare unit, and the last slot's registered
// read is used before the pass ends. Register and resolve give their one
// result once the scan pass ends. Epoch and tick give completions in
// ascending key order; drop gives none, only the end result. Each
// completion takes one more pass to find the smallest marked key, and a
// final pass finds none before the end result shows. busy is high from
// acceptance until the last result is shown.
// Reset (synchronous, active high) clears all slot valid bits, the current
// epoch and sets the deadline to 1000. Slot contents are not cleared.
module pending_command_timeout_tracker
   import pctt_pkg::*;
#(
   parameter int TABLE_DEPTH = DefaultTableDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [31:0] req_epoch,
   input  logic [31:0] req_generation,
   input  logic [7:0]  req_client_tag,
   input  logic [15:0] req_command_tag,
   input  logic [7:0]  req_completion_code,
   input  logic [31:0] req_now_ms,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_epoch_out,
   output logic [31:0] rsp_generation_out,
   output logic [7:0]  rsp_client_out,
   output logic [15:0] rsp_command_out,
   output logic [7:0]  rsp_completion_out,
   output logic [31:0] rsp_latency_ms,
   output logic        rsp_last
);

   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

   // Slot table memory and valid bits.
   logic [31:0] mem_epoch [TABLE_DEPTH];
   logic [31:0] mem_gen   [TABLE_DEPTH];
   logic [7:0]  mem_client[TABLE_DEPTH];
   logic [15:0] mem_cmd   [TABLE_DEPTH];
   logic [31:0] mem_time  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [TABLE_DEPTH-1:0] mark_ff, mark_in;

   // Registered read data.
   logic [31:0] rd_epoch_ff, rd_gen_ff, rd_time_ff;
   logic [7:0]  rd_client_ff;
   logic [15:0] rd_cmd_ff;
   logic        rd_valid_ff, rd_mark_ff;
   logic [IdxW-1:0] rd_idx_ff;
   logic        rd_live_ff;

   // Control registers.
   state_type state_ff, state_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [2:0]  op_ff;
   logic [31:0] ep_ff, gen_ff, now_ff;
   logic [7:0]  cl_ff, comp_ff;
   logic [15:0] cmd_ff;
   logic [31:0] cur_epoch_ff, cur_epoch_in;
   logic [15:0] deadline_ff;

   // Scan results: hit slot, free slot, best marked slot.
   logic            hit_ff, hit_in, free_ff, free_in, best_ff, best_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [IdxW-1:0] best_idx_ff, best_idx_in;
   logic [31:0] best_ep_ff, best_ep_in, best_gen_ff, best_gen_in;
   logic [7:0]  best_cl_ff, best_cl_in;
   logic [15:0] best_cmd_ff, best_cmd_in;
   logic [31:0] best_time_ff, best_time_in;

   logic accept;
   logic do_write;
   logic [IdxW-1:0] wr_idx;
   logic [31:0] age;
   logic key_eq, key_lt;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_epoch[wr_idx]  <= ep_ff;
         mem_gen[wr_idx]    <= gen_ff;
         mem_client[wr_idx] <= cl_ff;
         mem_cmd[wr_idx]    <= cmd_ff;
         mem_time[wr_idx]   <= now_ff;
      end
      rd_epoch_ff  <= mem_epoch[idx_ff];
      rd_gen_ff    <= mem_gen[idx_ff];
      rd_client_ff <= mem_client[idx_ff];
      rd_cmd_ff    <= mem_cmd[idx_ff];
      rd_time_ff   <= mem_time[idx_ff];
      rd_valid_ff  <= valid_ff[idx_ff];
      rd_mark_ff   <= mark_ff[idx_ff];
      rd_idx_ff    <= idx_ff;
   end

   // The shared compare unit working on the slot just read.
   assign age = now_ff - rd_time_ff;
   assign key_eq = (rd_epoch_ff == ep_ff) && (rd_gen_ff == gen_ff);
   assign key_lt = (rd_epoch_ff < best_ep_ff) ||
                   ((rd_epoch_ff == best_ep_ff) && (rd_gen_ff < best_gen_ff));

   // Next state. A pass ends once the last slot's read data has been used.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCAN;
         ST_SCAN:   if (rd_live_ff && rd_idx_ff == LastIdx) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (op_ff == OP_REGISTER || op_ff == OP_RESOLVE) state_in = ST_IDLE;
            else state_in = ST_PICK;
         end
         ST_PICK:   if (rd_live_ff && rd_idx_ff == LastIdx) state_in = ST_EMIT;
         ST_EMIT:   state_in = best_ff ? ST_PICK : ST_END;
         ST_END:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      mark_in = mark_ff;
      cur_epoch_in = cur_epoch_ff;
      hit_in = hit_ff; hit_idx_in = hit_idx_ff;
      free_in = free_ff; free_idx_in = free_idx_ff;
      best_in = best_ff; best_idx_in = best_idx_ff;
      best_ep_in = best_ep_ff; best_gen_in = best_gen_ff;
      best_cl_in = best_cl_ff; best_cmd_in = best_cmd_ff;
      best_time_in = best_time_ff;
      do_write = 1'b0;
      wr_idx = free_idx_ff;
      rsp_valid = 1'b0;
      rsp_kind = KIND_END;
      rsp_epoch_out = '0;
      rsp_generation_out = '0;
      rsp_client_out = '0;
      rsp_command_out = '0;
      rsp_completion_out = '0;
      rsp_latency_ms = '0;
      rsp_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            hit_in = 1'b0;
            free_in = 1'b0;
            best_in = 1'b0;
            mark_in = '0;
         end
         ST_SCAN: begin
            idx_in = (idx_ff == LastIdx) ? '0 : idx_ff + 1'b1;
         end
         ST_DECIDE: begin
            idx_in = '0;
            if (op_ff == OP_REGISTER) begin
               if (ep_ff > cur_epoch_ff) cur_epoch_in = ep_ff;
               rsp_valid = 1'b1;
               rsp_last = 1'b1;
               rsp_epoch_out = ep_ff;
               rsp_generation_out = gen_ff;
               rsp_client_out = cl_ff;
               rsp_command_out = cmd_ff;
               if (hit_ff || free_ff) begin
                  do_write = 1'b1;
                  wr_idx = hit_ff ? hit_idx_ff : free_idx_ff;
                  valid_in[wr_idx] = 1'b1;
                  rsp_kind = KIND_REGISTERED;
               end else begin
                  rsp_kind = KIND_FULL;
               end
            end else if (op_ff == OP_RESOLVE) begin
               rsp_valid = 1'b1;
               rsp_last = 1'b1;
               rsp_epoch_out = ep_ff;
               rsp_generation_out = gen_ff;
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  rsp_kind = KIND_RESOLVED;
                  rsp_client_out = best_cl_ff;
                  rsp_command_out = best_cmd_ff;
                  rsp_completion_out = comp_ff;
                  rsp_latency_ms = now_ff - best_time_ff;
               end else begin
                  rsp_kind = KIND_MISS;
               end
            end else if (op_ff == OP_EPOCH && ep_ff > cur_epoch_ff) begin
               cur_epoch_in = ep_ff;
            end
            best_in = 1'b0;
         end
         ST_PICK: begin
            idx_in = (idx_ff == LastIdx) ? '0 : idx_ff + 1'b1;
         end
         ST_EMIT: begin
            idx_in = '0;
            if (best_ff) begin
               rsp_valid = 1'b1;
               rsp_kind = (op_ff == OP_EPOCH) ? KIND_SUPERSEDED : KIND_TIMEOUT;
               rsp_epoch_out = best_ep_ff;
               rsp_generation_out = best_gen_ff;
               rsp_client_out = best_cl_ff;
               rsp_command_out = best_cmd_ff;
               rsp_latency_ms = now_ff - best_time_ff;
               mark_in[best_idx_ff] = 1'b0;
               valid_in[best_idx_ff] = 1'b0;
            end
            best_in = 1'b0;
         end
         ST_END: begin
            rsp_valid = 1'b1;
            rsp_kind = KIND_END;
            rsp_last = 1'b1;
         end
         default: ;
      endcase

      // Compare unit consumes the registered read data of the slot addressed in the previous cycle.
      if (rd_live_ff) begin
         if (state_ff == ST_SCAN || state_ff == ST_DECIDE) begin
            if (rd_valid_ff && key_eq && !hit_ff) begin
               hit_in = 1'b1;
               hit_idx_in = rd_idx_ff;
               best_cl_in = rd_client_ff;
               best_cmd_in = rd_cmd_ff;
               best_time_in = rd_time_ff;
            end
            if (!rd_valid_ff && !free_ff) begin
               free_in = 1'b1;
               free_idx_in = rd_idx_ff;
            end
            case (op_ff)
               OP_EPOCH:
                  mark_in[rd_idx_ff] = rd_valid_ff && (ep_ff > cur_epoch_ff) &&
                                       (rd_epoch_ff < ep_ff);
               OP_DROP:
                  if (rd_valid_ff && rd_client_ff == cl_ff) valid_in[rd_idx_ff] = 1'b0;
               OP_TICK:
                  mark_in[rd_idx_ff] = rd_valid_ff && (age >= 32'(deadline_ff));
               default: ;
            endcase
         end else if (rd_mark_ff && (!best_ff || key_lt)) begin
            best_in = 1'b1;
            best_idx_in = rd_idx_ff;
            best_ep_in = rd_epoch_ff;
            best_gen_in = rd_gen_ff;
            best_cl_in = rd_client_ff;
            best_cmd_in = rd_cmd_ff;
            best_time_in = rd_time_ff;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         mark_ff <= '0;
         cur_epoch_ff <= '0;
         deadline_ff <= DefaultDeadlineMs;
         rd_live_ff <= 1'b0;
         idx_ff <= '0;
         hit_ff <= 1'b0;
         free_ff <= 1'b0;
         best_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         mark_ff <= mark_in;
         cur_epoch_ff <= cur_epoch_in;
         rd_live_ff <= ((state_ff == ST_SCAN) || (state_ff == ST_PICK)) &&
                       !(rd_live_ff && (rd_idx_ff == LastIdx));
         idx_ff <= idx_in;
         hit_ff <= hit_in;
         free_ff <= free_in;
         best_ff <= best_in;
         if (csr_write_enable) begin
            deadline_ff <= (csr_write_data == '0) ? DefaultDeadlineMs : csr_write_data;
         end
      end
   end

   // Request and scan payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_operation;
         ep_ff <= req_epoch;
         gen_ff <= req_generation;
         cl_ff <= req_client_tag;
         cmd_ff <= req_command_tag;
         comp_ff <= req_completion_code;
         now_ff <= req_now_ms;
      end
      hit_idx_ff <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      best_idx_ff <= best_idx_in;
      best_ep_ff <= best_ep_in;
      best_gen_ff <= best_gen_in;
      best_cl_ff <= best_cl_in;
      best_cmd_ff <= best_cmd_in;
      best_time_ff <= best_time_in;
   end

endmodule

[rtl/core/pctt_checker.sv]
// Port-level checker for the pending command timeout tracker and its bind.
`timescale 1ns / 1ps
module pctt_checker
   import pctt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_kind,
   input logic       rsp_last
);

   // A result never appears while the block is idle.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");

   // The end result always carries last.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_END) |-> rsp_last) else $error("end without last");

   // After the last result the block is idle again.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy) else $error("busy after last");

   // An accepted request makes the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");

endmodule

bind pending_command_timeout_tracker pctt_checker u_pctt_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_last(rsp_last)
);
